// ===== rtl/hhq_pkg.sv =====
`timescale 1ns / 1ps

package hhq_pkg;

  // Fixed-point format and store geometry
  localparam int FRAC_BITS   = 8;
  localparam int MAX_SIDE    = 256;
  localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int H_W         = 24;
  localparam int POS_W       = 17;
  localparam int INT_W       = POS_W - 1 - FRAC_BITS;
  localparam int SIDE_W      = 9;
  localparam int SAMPLE_W    = 8;
  localparam int GAIN_W      = 16;
  localparam int W_W         = FRAC_BITS + 3;
  localparam int ACC_W       = H_W + FRAC_BITS + 3;
  localparam int LIN_W       = 2 * SIDE_W;

  // Stream payload layout
  localparam int IDX_LSB     = 0;
  localparam int SAMPLE_LSB  = IDX_LSB + ADDR_W;
  localparam int POSX_LSB    = SAMPLE_LSB + SAMPLE_W;
  localparam int POSZ_LSB    = POSX_LSB + POS_W;
  localparam int IN_BITS     = POSZ_LSB + POS_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((H_W + 7) / 8) * 8;

  // Configuration port
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = GAIN_W;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_DEPTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_GAIN = 2'd2;

  // Item kinds
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic       accept;
    logic       rd_en;
    logic [1:0] corner;
    logic       finish;
  } hhq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_read;
  } hhq_stat_t;

endpackage

// ===== rtl/hhq_ram.sv =====
`timescale 1ns / 1ps

module hhq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/hhq_ctrl.sv =====
`timescale 1ns / 1ps

module hhq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  logic               m_tready,
  input  hhq_pkg::hhq_stat_t stat,
  output hhq_pkg::hhq_cmd_t  cmd
);

  import hhq_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_READ   = 2'd1;
  localparam logic [1:0] ST_TAIL   = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  // Tail count at which the pipeline drain is complete
  localparam logic [1:0] TAIL_LAST = 2'd1;

  logic [1:0] state, state_next;
  logic [1:0] cnt, cnt_next;
  logic       accept, finish;

  assign s_tready = (state == ST_IDLE) && !rst;
  assign accept   = s_tvalid && s_tready;
  assign finish   = (state == ST_FINISH) && (!m_tvalid || m_tready);

  always_comb begin
    cmd.accept = accept;
    cmd.rd_en  = (state == ST_READ);
    cmd.corner = cnt;
    cmd.finish = finish;
  end

  // Sequencer: four corner reads and drain if needed; hand off result
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      ST_IDLE: begin
        cnt_next = '0;
        if (accept) begin
          state_next = stat.need_read ? ST_READ : ST_FINISH;
        end
      end
      ST_READ: begin
        cnt_next = cnt + 2'd1;
        if (cnt == 2'd3) begin
          state_next = ST_TAIL;
          cnt_next   = '0;
        end
      end
      ST_TAIL: begin
        cnt_next = cnt + 2'd1;
        if (cnt == TAIL_LAST) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (finish) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/hhq_datapath.sv =====
`timescale 1ns / 1ps

module hhq_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [hhq_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [hhq_pkg::CFG_W-1:0]           cfg_data,
  input  logic [hhq_pkg::IN_TDATA_W-1:0]      s_tdata,
  input  logic                                op,
  input  hhq_pkg::hhq_cmd_t                   cmd,
  output hhq_pkg::hhq_stat_t                  stat,
  output logic [hhq_pkg::H_W-1:0]             height_out,
  output logic                                on_map_out
);

  import hhq_pkg::*;

  localparam logic [W_W-1:0] S_W = W_W'(1 << FRAC_BITS);

  // Configuration and persistent state
  logic [SIDE_W-1:0] map_width, map_depth;
  logic [GAIN_W-1:0] height_gain;
  logic [H_W-1:0]    last_height;
  logic              map_loaded;

  // Input unpack
  logic [ADDR_W-1:0]    cell_index;
  logic [SAMPLE_W-1:0]  sample;
  logic [POS_W-1:0]     pos_x, pos_z;
  logic [INT_W-1:0]     fx, fz;
  logic [FRAC_BITS-1:0] dx, dz;
  logic [SIDE_W-1:0]    cx_raw, cz_raw, cx, cz, x_lim, z_lim;
  logic                 on_map_now, is_query, is_load;
  logic [W_W-1:0]       sdx, sdz, w1, w2, w3, w4;

  // Per-item registers
  logic [INT_W-1:0]  fx_q, fz_q;
  logic [SIDE_W-1:0] cx_q, cz_q;
  logic [W_W-1:0]    w_q [4];
  logic              direct_q, on_map_q;
  logic [H_W-1:0]    direct_h_q;

  // Read and accumulate pipeline
  logic [SIDE_W-1:0] row_sel, col_sel;
  logic [LIN_W-1:0]  lin;
  logic [ADDR_W-1:0] ram_addr;
  logic [H_W-1:0]    ram_wdata, ram_rdata;
  logic              ram_we;
  logic              v1, v2;
  logic [1:0]        k1;
  logic [ACC_W-1:0]  prod, acc;
  logic [H_W-1:0]    tri_res;

  assign cell_index = s_tdata[IDX_LSB +: ADDR_W];
  assign sample     = s_tdata[SAMPLE_LSB +: SAMPLE_W];
  assign pos_x      = s_tdata[POSX_LSB +: POS_W];
  assign pos_z      = s_tdata[POSZ_LSB +: POS_W];
  assign is_query   = (op == OP_QUERY);
  assign is_load    = (op == OP_LOAD);

  // Position decode, map bounds and clamped ceil corners
  assign fx = pos_x[FRAC_BITS +: INT_W];
  assign fz = pos_z[FRAC_BITS +: INT_W];
  assign dx = pos_x[FRAC_BITS-1:0];
  assign dz = pos_z[FRAC_BITS-1:0];

  assign on_map_now = !pos_x[POS_W-1] && !pos_z[POS_W-1]
                   && ({1'b0, pos_x[POS_W-2:0]} < {map_width, {FRAC_BITS{1'b0}}})
                   && ({1'b0, pos_z[POS_W-2:0]} < {map_depth, {FRAC_BITS{1'b0}}});

  assign cx_raw = SIDE_W'(fx) + SIDE_W'(dx != '0);
  assign cz_raw = SIDE_W'(fz) + SIDE_W'(dz != '0);
  assign x_lim  = map_width - SIDE_W'(1);
  assign z_lim  = map_depth - SIDE_W'(1);
  assign cx     = (cx_raw > x_lim) ? x_lim : cx_raw;
  assign cz     = (cz_raw > z_lim) ? z_lim : cz_raw;

  assign stat.need_read = is_query && on_map_now && map_loaded;

  // Corner weights; the diagonal case is scaled by four to share the final shift
  assign sdx = S_W - W_W'(dx);
  assign sdz = S_W - W_W'(dz);
  always_comb begin
    if (dx > dz) begin
      w1 = sdz + W_W'(0) + sdx - sdz;
      w2 = '0;
      w3 = W_W'(dx) + sdz;
      w4 = W_W'(dz);
    end else if (dz > dx) begin
      w1 = sdz;
      w2 = W_W'(dz) + sdx;
      w3 = '0;
      w4 = W_W'(dx);
    end else begin
      w1 = sdx << 2;
      w2 = '0;
      w3 = '0;
      w4 = W_W'(dx) << 2;
    end
  end

  // Store port: load write on accept, otherwise corner reads
  assign row_sel   = cmd.corner[1] ? cz_q : SIDE_W'(fz_q);
  assign col_sel   = cmd.corner[0] ? cx_q : SIDE_W'(fx_q);
  assign lin       = LIN_W'(row_sel) * LIN_W'(map_width) + LIN_W'(col_sel);
  assign ram_we    = cmd.accept && is_load;
  assign ram_addr  = ram_we ? cell_index : lin[ADDR_W-1:0];
  assign ram_wdata = H_W'(sample) * H_W'(height_gain);

  hhq_ram #(
    .WIDTH (H_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign tri_res = acc[FRAC_BITS + 2 +: H_W];

  // Configuration registers and block state
  always_ff @(posedge clk) begin
    if (rst) begin
      map_width   <= SIDE_W'(MAX_SIDE);
      map_depth   <= SIDE_W'(MAX_SIDE);
      height_gain <= GAIN_W'(1 << FRAC_BITS);
      last_height <= '0;
      map_loaded  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_MAP_WIDTH:   map_width   <= cfg_data[SIDE_W-1:0];
          REG_MAP_DEPTH:   map_depth   <= cfg_data[SIDE_W-1:0];
          REG_HEIGHT_GAIN: height_gain <= cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (ram_we) begin
        map_loaded <= 1'b1;
      end
      if (cmd.finish && !direct_q) begin
        last_height <= tri_res;
      end
    end
  end

  // Pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.rd_en;
      v2 <= v1;
    end
  end

  // Item capture, multiply-accumulate and result register
  always_ff @(posedge clk) begin
    k1 <= cmd.corner;
    if (cmd.accept) begin
      fx_q       <= fx;
      fz_q       <= fz;
      cx_q       <= cx;
      cz_q       <= cz;
      w_q[0]     <= w1;
      w_q[1]     <= w2;
      w_q[2]     <= w3;
      w_q[3]     <= w4;
      direct_q   <= !stat.need_read;
      on_map_q   <= is_query && on_map_now;
      direct_h_q <= (is_query && on_map_now) ? last_height : '0;
      acc        <= (dx != dz) ? (ACC_W'(last_height) << (FRAC_BITS + 1)) : '0;
    end else if (v2) begin
      acc <= acc + prod;
    end
    if (v1) begin
      prod <= ACC_W'(ram_rdata) * ACC_W'(w_q[k1]);
    end
    if (cmd.finish) begin
      height_out <= direct_q ? direct_h_q : tri_res;
      on_map_out <= on_map_q;
    end
  end

endmodule

// ===== rtl/heightmap_height_query.sv =====
`timescale 1ns / 1ps

// Height map store with interpolated height queries.
// Input stream (s_*): one transaction per item. s_tuser carries the kind
// (0 load one cell, 1 height query). A load writes sample times height_gain
// into the cell at cell_index; a query returns the height under pos_x/pos_z.
// Output stream (m_*): exactly one transaction per input item, in order.
// m_tdata is the Q16.8 height, m_tuser is on_map.
// Configuration: cfg_we/cfg_idx/cfg_data write map_width (0), map_depth (1)
// and height_gain (2); write only while no item is in flight.
// Sequence: a load, an off-map query or a query before any load goes from
// acceptance straight to the result hand-off. An interpolating query reads its four
// corners one per cycle from the single-port height memory, then drains a
// two-stage multiply-accumulate before its result is handed off. A new item is
// accepted only once the previous result has been handed to the output register.
// A finished result sits in the output register while the next item is
// accepted and worked on; if the receiver stalls, the block holds that next
// result until the output register frees up.
// Reset clears the registers to their defaults, the previous height and the
// loaded flag; the height memory is not cleared.
module heightmap_height_query (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [hhq_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [hhq_pkg::CFG_W-1:0]        cfg_data,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // cell_index[15:0], sample[23:16], pos_x[40:24], pos_z[57:41], zero fill
  input  logic [hhq_pkg::IN_TDATA_W-1:0]   s_tdata,
  // op[0]
  input  logic [0:0]                       s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // height_out[23:0]
  output logic [hhq_pkg::OUT_TDATA_W-1:0]  m_tdata,
  // on_map[0]
  output logic [0:0]                       m_tuser
);

  import hhq_pkg::*;

  hhq_cmd_t       cmd;
  hhq_stat_t      stat;
  logic [H_W-1:0] height_out;
  logic           on_map_out;

  hhq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  hhq_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .s_tdata    (s_tdata),
    .op         (s_tuser[0]),
    .cmd        (cmd),
    .stat       (stat),
    .height_out (height_out),
    .on_map_out (on_map_out)
  );

  assign m_tdata = OUT_TDATA_W'(height_out);
  assign m_tuser = on_map_out;

endmodule
